### src/hgo_pkg.sv
// Shared types, codes and helpers for the high-gain observer filter.
// Used by hgo_mul_unit, hgo_sequencer and high_gain_observer_filter.
package hgo_pkg;

   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_POSITION_GAIN = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SPEED_GAIN    = 8'd1;

   localparam logic [31:0] POSITION_GAIN_RESET = 32'd32768000;
   localparam logic [31:0] SPEED_GAIN_RESET    = 32'd15360000;

   typedef struct packed {
      logic [23:0]        time_step;
      logic signed [31:0] measured_angle;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] angle_estimate;
      logic signed [31:0] speed_estimate;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LO,
      ST_HI,
      ST_SUM,
      ST_FINAL
   } seq_state_type;

   typedef enum logic [2:0] {
      OP_DRIFT,
      OP_KP,
      OP_KV,
      OP_PCORR,
      OP_VCORR
   } op_type;

   typedef struct packed {
      logic mul_lo;
      logic mul_hi;
   } mul_ctl_type;

   typedef struct packed {
      mul_ctl_type mul;
      op_type      op;
      logic        retire;
      logic        fold_drift;
      logic        finish;
      logic        idle;
   } seq_ctl_type;

   // Clamp a wide signed sum to 32-bit signed.
   function automatic logic signed [31:0] sat32(input logic signed [57:0] v);
      logic signed [31:0] r;
      if ((&v[57:31]) || !(|v[57:31])) begin
         r = v[31:0];
      end else if (v[57]) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'sh7fff_ffff;
      end
      return r;
   endfunction

endpackage

### src/hgo_mul_unit.sv
// Shared multiply-accumulate unit: 33-bit signed by 32-bit unsigned in two halves.
// Depends on hgo_pkg for the control struct.
module hgo_mul_unit (
   input  logic                clock,
   input  hgo_pkg::mul_ctl_type ctl,
   input  logic signed [32:0]  a,
   input  logic [31:0]         b,
   output logic signed [65:0]  sum
);
   import hgo_pkg::*;

   logic signed [16:0] b_half;
   logic signed [49:0] prod_in;
   logic signed [49:0] prod_ff;
   logic signed [65:0] acc_ff;

   assign b_half  = ctl.mul_hi ? $signed({1'b0, b[31:16]}) : $signed({1'b0, b[15:0]});
   assign prod_in = a * b_half;

   always_ff @(posedge clock) begin
      if (ctl.mul_lo || ctl.mul_hi) begin
         prod_ff <= prod_in;
      end
      // prod_ff holds the low partial product while the high one is formed
      if (ctl.mul_hi) begin
         acc_ff <= 66'(prod_ff);
      end
   end

   assign sum = acc_ff + (66'(prod_ff) <<< 16);

endmodule

### src/hgo_sequencer.sv
// Sequencer that steps the shared multiplier through the five products of one word.
// Depends on hgo_pkg for state, operation and control types.
module hgo_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 out_blocked,
   output hgo_pkg::seq_ctl_type ctl
);
   import hgo_pkg::*;

   seq_state_type state_ff, state_in;
   op_type        op_ff, op_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_DRIFT;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      ctl            = '0;
      ctl.op         = op_ff;
      case (state_ff)
         ST_IDLE: begin
            ctl.idle = 1'b1;
            if (start) begin
               state_in = ST_LO;
               op_in    = OP_DRIFT;
            end
         end
         ST_LO: begin
            ctl.mul.mul_lo = 1'b1;
            ctl.fold_drift = (op_ff == OP_KP);
            state_in       = ST_HI;
         end
         ST_HI: begin
            ctl.mul.mul_hi = 1'b1;
            state_in       = ST_SUM;
         end
         ST_SUM: begin
            ctl.retire = 1'b1;
            state_in   = ST_LO;
            case (op_ff)
               OP_DRIFT: op_in = OP_KP;
               OP_KP:    op_in = OP_KV;
               OP_KV:    op_in = OP_PCORR;
               OP_PCORR: op_in = OP_VCORR;
               OP_VCORR: state_in = ST_FINAL;
               default:  state_in = ST_IDLE;
            endcase
         end
         ST_FINAL: begin
            if (!out_blocked) begin
               ctl.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### src/high_gain_observer_filter.sv
// Top level of the high-gain observer (alpha-beta) angle and speed filter.
// Depends on hgo_pkg, hgo_mul_unit and hgo_sequencer.
//
//   channel   direction  handshake                word
//   req_      in         req_valid / req_ready    req_word_type (time_step, measured_angle)
//   rsp_      out        rsp_valid / rsp_ready    rsp_word_type (angle_estimate, speed_estimate)
//   csr_      in         csr_valid / csr_ready    csr_index, csr_data
//
// Each word runs five products (drift, two gain scalings, two corrections) through
// low, high and sum steps on the shared 33x17 multiplier, then a final step for the
// adds and clamping that loads the result register. req_ready is high only while
// the sequencer is idle, so a new word is taken only once the last one is finished.
// csr_ready is always high.
// Synchronous reset clears the estimates, restores the gain defaults and drops rsp_valid.
// A result waits in the output register; a later word holds in its final cycle
// until that result is taken.
module high_gain_observer_filter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  hgo_pkg::req_word_type               req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output hgo_pkg::rsp_word_type               rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hgo_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [hgo_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import hgo_pkg::*;

   seq_ctl_type ctl;
   logic        start;
   logic        out_blocked;

   // Configuration and filter state
   logic [31:0]        position_gain_ff;
   logic [31:0]        speed_gain_ff;
   logic signed [31:0] last_angle_ff;
   logic signed [31:0] last_speed_ff;

   // Per-word working registers
   logic [23:0]        time_step_ff;
   logic signed [32:0] innovation_ff;
   logic signed [31:0] drift_ff;
   logic signed [33:0] drift_angle_ff;
   logic [31:0]        kp_ff;
   logic [31:0]        kv_ff;
   logic signed [48:0] pcorr_ff;
   logic signed [56:0] vcorr_ff;

   logic               rsp_valid_ff;
   rsp_word_type       rsp_data_ff;

   logic signed [32:0] mul_a;
   logic [31:0]        mul_b;
   logic signed [65:0] mul_sum;
   logic signed [31:0] angle_in;
   logic signed [31:0] speed_in;

   assign req_ready   = ctl.idle;
   assign start       = req_valid && ctl.idle;
   assign out_blocked = rsp_valid_ff && !rsp_ready;
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_data_ff;

   hgo_sequencer u_sequencer (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .out_blocked (out_blocked),
      .ctl         (ctl)
   );

   // Route operands of the current product into the shared multiplier.
   always_comb begin
      case (ctl.op)
         OP_DRIFT: begin
            mul_a = $signed({last_speed_ff[31], last_speed_ff});
            mul_b = {8'd0, time_step_ff};
         end
         OP_KP: begin
            mul_a = $signed({9'd0, time_step_ff});
            mul_b = position_gain_ff;
         end
         OP_KV: begin
            mul_a = $signed({9'd0, time_step_ff});
            mul_b = speed_gain_ff;
         end
         OP_PCORR: begin
            mul_a = innovation_ff;
            mul_b = kp_ff;
         end
         OP_VCORR: begin
            mul_a = innovation_ff;
            mul_b = kv_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   hgo_mul_unit u_mul_unit (
      .clock (clock),
      .ctl   (ctl.mul),
      .a     (mul_a),
      .b     (mul_b),
      .sum   (mul_sum)
   );

   // Final adds with clamping; products are already floored by bit selection.
   assign angle_in = sat32(58'(drift_angle_ff) + 58'(pcorr_ff));
   assign speed_in = sat32(58'(last_speed_ff) + 58'(vcorr_ff));

   // Configuration writes, filter state and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         position_gain_ff <= POSITION_GAIN_RESET;
         speed_gain_ff    <= SPEED_GAIN_RESET;
         last_angle_ff    <= '0;
         last_speed_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         // Drop writes to indexes beyond the register list.
         if (csr_valid && csr_index == REG_POSITION_GAIN) begin
            position_gain_ff <= csr_data;
         end
         if (csr_valid && csr_index == REG_SPEED_GAIN) begin
            speed_gain_ff <= csr_data;
         end
         if (ctl.finish) begin
            last_angle_ff <= angle_in;
            last_speed_ff <= speed_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Working registers: capture the word, retire each product, fold the drift.
   always_ff @(posedge clock) begin
      if (start) begin
         time_step_ff  <= req_data.time_step;
         innovation_ff <= $signed({req_data.measured_angle[31], req_data.measured_angle})
                        - $signed({last_angle_ff[31], last_angle_ff});
      end
      if (ctl.retire) begin
         case (ctl.op)
            OP_DRIFT: drift_ff <= mul_sum[55:24];
            OP_KP:    kp_ff    <= mul_sum[55:24];
            OP_KV:    kv_ff    <= mul_sum[55:24];
            OP_PCORR: pcorr_ff <= mul_sum[64:16];
            OP_VCORR: vcorr_ff <= mul_sum[64:8];
            default:  ;
         endcase
      end
      // Fold previous angle and drift while the gain products run.
      if (ctl.fold_drift) begin
         drift_angle_ff <= 34'(last_angle_ff) + 34'(drift_ff);
      end
      if (ctl.finish) begin
         rsp_data_ff.angle_estimate <= angle_in;
         rsp_data_ff.speed_estimate <= speed_in;
      end
   end

endmodule

### bench/testbench.sv
// Self-checking bench for high_gain_observer_filter: directed and random encoder words.
// Depends on hgo_pkg and the high_gain_observer_filter RTL; an in-bench predictor
// tracks angle and speed and checks every result word in order.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import hgo_pkg::*;

   // The block holds a word until its result is done; give it a margin before touching registers.
   localparam int SETTLE_CYCLES = 24;
   // Watchdog limit, set well above the length of the slowest correct run.
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_WORDS_PER_SETTING = 90;

   // Register indexes that decode to nothing; writes there must be dropped.
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UNUSED = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TOP    = 8'hff;

   localparam logic signed [79:0] Q_MAX = 80'sd2147483647;
   localparam logic signed [79:0] Q_MIN = -80'sd2147483648;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid = 1'b0;
   logic                       req_ready;
   req_word_type               req_data  = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   rsp_word_type               rsp_data;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data  = '0;

   // Predictor state: gains as last written, estimates as last emitted.
   logic [31:0]        pos_gain = POSITION_GAIN_RESET;
   logic [31:0]        spd_gain = SPEED_GAIN_RESET;
   logic signed [31:0] est_angle = '0;
   logic signed [31:0] est_speed = '0;

   rsp_word_type expected_estimates[$];
   int mismatch_count = 0;
   int cycle_count = 0;
   int burst_left = 0;

   // Receiver stall pattern: mode and how long it lasts.
   int stall_mode = 0;
   int stall_span = 0;
   int stall_phase = 0;

   high_gain_observer_filter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Clamp an exact sum to the signed 32-bit range of the estimates.
   function automatic logic signed [31:0] clamp_q16(input logic signed [79:0] v);
      if (v > Q_MAX) begin
         return 32'sh7fff_ffff;
      end
      if (v < Q_MIN) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   // Advance the observer by one measurement. All products are exact in 80 bits,
   // and an arithmetic right shift of a signed product rounds toward minus infinity.
   function automatic rsp_word_type advance_observer(input req_word_type word);
      logic signed [79:0] dt, p_gain, v_gain, angle, speed, innov;
      logic signed [79:0] kp, kv, drift, pcorr, vcorr;
      rsp_word_type result_word;
      dt     = $signed({56'd0, word.time_step});
      p_gain = $signed({48'd0, pos_gain});
      v_gain = $signed({48'd0, spd_gain});
      angle  = est_angle;
      speed  = est_speed;
      innov  = $signed(word.measured_angle) - angle;
      // Scale the gains by the time step first, then apply them to the innovation.
      kp     = (dt * p_gain) >>> 24;
      kv     = (dt * v_gain) >>> 24;
      drift  = (speed * dt) >>> 24;
      pcorr  = (kp * innov) >>> 16;
      vcorr  = (kv * innov) >>> 8;
      result_word.angle_estimate = clamp_q16(angle + drift + pcorr);
      result_word.speed_estimate = clamp_q16(speed + vcorr);
      // The clamped values become the new state.
      est_angle = result_word.angle_estimate;
      est_speed = result_word.speed_estimate;
      return result_word;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0d] mismatch: %s", cycle_count, what);
      mismatch_count++;
   endtask

   // Send one word. Between bursts drop valid for a random gap; within a burst
   // keep valid high so back-to-back words go out with no bubble.
   task automatic send_word(input req_word_type word);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0 && req_valid) begin
            req_valid <= 1'b0;
         end
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= word;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // Accepted at this edge: predict now, in acceptance order.
      expected_estimates.push_back(advance_observer(word));
   endtask

   function automatic req_word_type make_word(input logic [23:0] dt,
                                              input logic [31:0] angle);
      req_word_type word;
      word.time_step      = dt;
      word.measured_angle = angle;
      return word;
   endfunction

   // Hold off the sender until every expected result is in, then let the block settle.
   task automatic wait_for_idle;
      if (req_valid) begin
         req_valid <= 1'b0;
      end
      burst_left = 0;
      while (expected_estimates.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one register; the predictor takes the value at the handshake.
   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                 input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (index == REG_POSITION_GAIN) begin
         pos_gain = value;
      end else if (index == REG_SPEED_GAIN) begin
         spd_gain = value;
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_gains(input logic [31:0] p_value, input logic [31:0] v_value);
      wait_for_idle();
      write_register(REG_POSITION_GAIN, p_value);
      write_register(REG_SPEED_GAIN, v_value);
   endtask

   // Zero time step, a first step and a reversal with the gains left at reset.
   task automatic test_reset_gains;
      send_word(make_word(24'd0, 32'd0));
      send_word(make_word(24'd0, 32'h7fff_ffff));
      send_word(make_word(24'd16777, 32'd65536));
      send_word(make_word(24'd16777, 32'd65536));
      send_word(make_word(24'd16777, -32'sd65536));
   endtask

   // Full time steps with extreme angles drive both estimates into the clamp.
   task automatic test_saturation;
      send_word(make_word(24'hff_ffff, 32'h7fff_ffff));
      send_word(make_word(24'hff_ffff, 32'h8000_0000));
      send_word(make_word(24'd0, 32'd0));
      send_word(make_word(24'hff_ffff, 32'h8000_0000));
      send_word(make_word(24'd1, 32'h7fff_ffff));
   endtask

   // Gain extremes and writes to indexes that decode to nothing.
   task automatic test_gain_extremes;
      set_gains(32'd0, 32'd0);
      send_word(make_word(24'hff_ffff, 32'h7fff_ffff));
      send_word(make_word(24'hff_ffff, 32'h8000_0000));
      set_gains(32'hffff_ffff, 32'hffff_ffff);
      send_word(make_word(24'hff_ffff, 32'h7fff_ffff));
      send_word(make_word(24'hff_ffff, 32'h8000_0000));
      send_word(make_word(24'h00_0001, 32'h0000_0001));
      wait_for_idle();
      write_register(REG_UNUSED, $urandom);
      write_register(REG_TOP, $urandom);
      send_word(make_word(24'h80_0000, 32'h1234_5678));
      send_word(make_word(24'h7f_ffff, 32'hedcb_a988));
   endtask

   // A shaft turning at a steady speed, sampled at roughly kilohertz rates with
   // small sensor noise; start from the current estimate so the filter can lock.
   task automatic run_tracking_segment(input int count);
      int unsigned dt;
      longint advance;
      int noise;
      logic signed [31:0] speed;
      logic signed [31:0] truth;
      speed = int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      truth = est_angle;
      for (int i = 0; i < count; i++) begin
         dt = $urandom_range(4000, 40000);
         if ($urandom_range(0, 19) == 0) begin
            dt = 0;
         end
         advance = (longint'(speed) * longint'(dt)) >>> 24;
         truth   = truth + 32'(advance);
         noise   = int'($urandom_range(0, 4000)) - 2000;
         send_word(make_word(dt[23:0], truth + noise));
      end
   endtask

   // Arbitrary words over the whole field range; these break any tracking.
   task automatic run_noise_burst(input int count);
      for (int i = 0; i < count; i++) begin
         send_word(make_word(24'($urandom), $urandom));
      end
   endtask

   task automatic run_random_mix(input int total);
      int sent;
      int count;
      sent = 0;
      while (sent < total) begin
         if ($urandom_range(0, 3) == 0) begin
            count = $urandom_range(1, 5);
            run_noise_burst(count);
         end else begin
            count = $urandom_range(10, 40);
            run_tracking_segment(count);
         end
         sent += count;
      end
   endtask

   // Random traffic over a sweep of gain settings.
   task automatic test_random_tracking;
      set_gains(POSITION_GAIN_RESET, SPEED_GAIN_RESET);
      run_random_mix(RANDOM_WORDS_PER_SETTING);
      set_gains($urandom, $urandom);
      run_random_mix(RANDOM_WORDS_PER_SETTING);
      set_gains($urandom_range(0, 32'h0010_0000), $urandom_range(0, 32'h0010_0000));
      run_random_mix(RANDOM_WORDS_PER_SETTING);
      set_gains(32'hffff_ffff, 32'hffff_ffff);
      run_random_mix(RANDOM_WORDS_PER_SETTING);
      set_gains(32'd0, $urandom);
      run_random_mix(RANDOM_WORDS_PER_SETTING);
   endtask

   // Stop sending until the pipeline has drained completely, then resume.
   task automatic test_drained_pause;
      run_tracking_segment(10);
      wait_for_idle();
      run_tracking_segment(10);
   endtask

   // Receiver stall pattern and result checking share the clock edge.
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (stall_span == 0) begin
            stall_mode  = $urandom_range(0, 3);
            stall_span  = $urandom_range(20, 200);
            stall_phase = 0;
         end
         stall_span--;
         stall_phase++;
         case (stall_mode)
            0: begin
               rsp_ready <= 1'b1;
            end
            1: begin
               rsp_ready <= 1'($urandom_range(0, 1));
            end
            2: begin
               rsp_ready <= (stall_phase % 4) == 0;
            end
            default: begin
               rsp_ready <= $urandom_range(0, 7) == 0;
            end
         endcase

         if (rsp_valid && rsp_ready) begin
            if (expected_estimates.size() == 0) begin
               report_mismatch($sformatf("result with nothing expected: angle %0d speed %0d",
                                         rsp_data.angle_estimate, rsp_data.speed_estimate));
            end else begin
               want = expected_estimates.pop_front();
               if (rsp_data.angle_estimate !== want.angle_estimate) begin
                  report_mismatch($sformatf("angle_estimate got %0d want %0d",
                                            rsp_data.angle_estimate, want.angle_estimate));
               end
               if (rsp_data.speed_estimate !== want.speed_estimate) begin
                  report_mismatch($sformatf("speed_estimate got %0d want %0d",
                                            rsp_data.speed_estimate, want.speed_estimate));
               end
            end
         end
      end
   end

   // Watchdog: a hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("high_gain_observer_filter test failed");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_gains();
      test_saturation();
      test_gain_extremes();
      test_random_tracking();
      test_drained_pause();

      wait_for_idle();
      if (mismatch_count == 0) begin
         $display("high_gain_observer_filter test passed");
      end else begin
         $display("high_gain_observer_filter test failed");
      end
      $finish;
   end

endmodule

### files.f
src/hgo_pkg.sv
src/hgo_mul_unit.sv
src/hgo_sequencer.sv
src/high_gain_observer_filter.sv
bench/testbench.sv
